// ----- src/hsv2rgb_pkg.sv -----
// ============================================================================
// hsv2rgb_pkg
// Shared types and constants for the HSV to RGB pixel converter: beat
// payloads, the hue sector code, per-stage control and hue sector helpers.
// ============================================================================
`default_nettype none

package hsv2rgb_pkg;

  localparam int HUE_W  = 15;
  localparam int CHAN_W = 13;
  localparam int REM_W  = 12;

  // Hue circle: 360 degrees at 1/64 degree, one 60 degree sector
  localparam logic [HUE_W-1:0] HUE_FULL   = 15'd23040;
  localparam logic [HUE_W-1:0] HUE_SECTOR = 15'd3840;

  // Rising edges from the one that takes a start to the one that takes its done
  localparam int PIPE_LATENCY = 6;

  typedef struct packed {
    logic [HUE_W-1:0]  hue;
    logic [CHAN_W-1:0] saturation;
    logic [CHAN_W-1:0] brightness;
  } hsv_pixel_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_pixel_t;

  typedef enum logic [2:0] {
    SEC_RED     = 3'd0,
    SEC_YELLOW  = 3'd1,
    SEC_GREEN   = 3'd2,
    SEC_CYAN    = 3'd3,
    SEC_BLUE    = 3'd4,
    SEC_MAGENTA = 3'd5
  } sector_t;

  typedef struct packed {
    logic    valid;
    sector_t sector;
  } stage_ctrl_t;

  // Pick the 60 degree sector of a wrapped hue
  function automatic sector_t hue_sector(input logic [HUE_W-1:0] hue);
    sector_t sec;
    priority if (hue >= 15'(5 * HUE_SECTOR)) sec = SEC_MAGENTA;
    else if (hue >= 15'(4 * HUE_SECTOR))     sec = SEC_BLUE;
    else if (hue >= 15'(3 * HUE_SECTOR))     sec = SEC_CYAN;
    else if (hue >= 15'(2 * HUE_SECTOR))     sec = SEC_GREEN;
    else if (hue >= HUE_SECTOR)              sec = SEC_YELLOW;
    else                                     sec = SEC_RED;
    return sec;
  endfunction

  // Hue at the start of a sector
  function automatic logic [HUE_W-1:0] sector_base(input sector_t sec);
    logic [HUE_W-1:0] base;
    unique case (sec)
      SEC_RED:     base = '0;
      SEC_YELLOW:  base = HUE_SECTOR;
      SEC_GREEN:   base = 15'(2 * HUE_SECTOR);
      SEC_CYAN:    base = 15'(3 * HUE_SECTOR);
      SEC_BLUE:    base = 15'(4 * HUE_SECTOR);
      SEC_MAGENTA: base = 15'(5 * HUE_SECTOR);
      default:     base = '0;
    endcase
    return base;
  endfunction

endpackage

`default_nettype wire

// ----- src/hsv_to_rgb_pixel_convert.sv -----
// ============================================================================
// hsv_to_rgb_pixel_convert
// HSV to RGB pixel converter, six register stages, one pixel per clock.
// ============================================================================
// Usage:
//   Input beat: drive hsv and raise start. A beat is taken at every rising
//   edge with start high and busy low; busy stays low, so a new pixel may
//   enter on every clock.
//   Output beat: rgb is shown for exactly one cycle with done high. done
//   and rgb are registered together in the channel routing stage. Results
//   leave in input order, one per input, and the receiver must take each
//   one as it appears.
//   Throughput: one pixel per cycle. The six register stages are hue
//   split, reciprocal multiply, fraction correction, s*f products, v
//   products and channel routing.
//   Hue at or above 360 degrees wraps to zero; saturation and value above
//   one are clamped to one.
//   Reset (rst, synchronous) clears every valid bit: beats in flight are
//   dropped and done stays low until a new beat has passed the pipeline.
// ============================================================================
`default_nettype none

module hsv_to_rgb_pixel_convert #(
  parameter int FRAC_BITS = 12
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  output logic                         busy,
  input  wire hsv2rgb_pkg::hsv_pixel_t hsv,
  output logic                         done,
  output hsv2rgb_pkg::rgb_pixel_t      rgb
);
  import hsv2rgb_pkg::*;

  localparam int VW = FRAC_BITS + 1;
  localparam int XW = (VW > CHAN_W) ? VW : CHAN_W;

  stage_ctrl_t   split_ctrl;
  logic [VW-1:0] split_frac;
  logic [VW-1:0] split_sat;
  logic [VW-1:0] split_val;

  stage_ctrl_t   shade_ctrl;
  logic [VW-1:0] shade_val;
  logic [VW-1:0] shade_p;
  logic [VW-1:0] shade_q;
  logic [VW-1:0] shade_t;

  logic [VW-1:0] red_lvl;
  logic [VW-1:0] green_lvl;
  logic [VW-1:0] blue_lvl;
  logic [XW-1:0] red_ext;
  logic [XW-1:0] green_ext;
  logic [XW-1:0] blue_ext;
  rgb_pixel_t    rgb_next;

  // The pipeline never holds input off
  assign busy = 1'b0;

  hsv2rgb_sector #(
    .FRAC_BITS (FRAC_BITS)
  ) u_sector (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start && !busy),
    .pixel    (hsv),
    .out_ctrl (split_ctrl),
    .out_frac (split_frac),
    .out_sat  (split_sat),
    .out_val  (split_val)
  );

  hsv2rgb_shade #(
    .FRAC_BITS (FRAC_BITS)
  ) u_shade (
    .clk      (clk),
    .rst      (rst),
    .in_ctrl  (split_ctrl),
    .in_frac  (split_frac),
    .in_sat   (split_sat),
    .in_val   (split_val),
    .out_ctrl (shade_ctrl),
    .out_val  (shade_val),
    .out_p    (shade_p),
    .out_q    (shade_q),
    .out_t    (shade_t)
  );

  // Route v, p, q and t to the channels by sector
  always_comb begin
    unique case (shade_ctrl.sector)
      SEC_RED: begin
        red_lvl = shade_val; green_lvl = shade_t;   blue_lvl = shade_p;
      end
      SEC_YELLOW: begin
        red_lvl = shade_q;   green_lvl = shade_val; blue_lvl = shade_p;
      end
      SEC_GREEN: begin
        red_lvl = shade_p;   green_lvl = shade_val; blue_lvl = shade_t;
      end
      SEC_CYAN: begin
        red_lvl = shade_p;   green_lvl = shade_q;   blue_lvl = shade_val;
      end
      SEC_BLUE: begin
        red_lvl = shade_t;   green_lvl = shade_p;   blue_lvl = shade_val;
      end
      default: begin
        red_lvl = shade_val; green_lvl = shade_p;   blue_lvl = shade_q;
      end
    endcase
  end

  // Fit each channel to the output width, dropping bits above it
  always_comb begin
    red_ext        = XW'(red_lvl);
    green_ext      = XW'(green_lvl);
    blue_ext       = XW'(blue_lvl);
    rgb_next.red   = red_ext[CHAN_W-1:0];
    rgb_next.green = green_ext[CHAN_W-1:0];
    rgb_next.blue  = blue_ext[CHAN_W-1:0];
  end

  // Output strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= shade_ctrl.valid;
    end
  end

  // Output beat payload
  always_ff @(posedge clk) begin
    rgb <= rgb_next;
  end

endmodule

`default_nettype wire

// ----- src/hsv2rgb_sector.sv -----
// ============================================================================
// hsv2rgb_sector
// Stages 1 to 3: clamp saturation and value, wrap the hue, find its sector
// and remainder, then form the in-sector fraction rem * ONE / 3840 with a
// reciprocal multiply and one correction step.
// ============================================================================
`default_nettype none

module hsv2rgb_sector #(
  parameter int FRAC_BITS = 12
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  input  wire hsv2rgb_pkg::hsv_pixel_t  pixel,
  output hsv2rgb_pkg::stage_ctrl_t      out_ctrl,
  output logic [FRAC_BITS:0]            out_frac,
  output logic [FRAC_BITS:0]            out_sat,
  output logic [FRAC_BITS:0]            out_val
);
  import hsv2rgb_pkg::*;

  localparam int VW = FRAC_BITS + 1;
  localparam int XW = (VW > CHAN_W) ? VW : CHAN_W;
  // Scaled remainder width: rem < 3840 shifted by FRAC_BITS - 8
  localparam int XB = FRAC_BITS + 4;
  localparam longint unsigned RECIP_L = (64'd1 << XB) / 64'd15;
  localparam logic [XB-1:0]   RECIP   = RECIP_L[XB-1:0];
  localparam logic [VW-1:0]   ONE     = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [XB-1:0]   FIFTEEN = XB'(15);

  // Stage 1 registers
  stage_ctrl_t      ctrl1;
  logic [REM_W-1:0] rem1;
  logic [VW-1:0]    sat1;
  logic [VW-1:0]    val1;

  // Stage 2 registers
  stage_ctrl_t      ctrl2;
  logic [XB-1:0]    scaled2;
  logic [2*XB-1:0]  prod2;
  logic [VW-1:0]    sat2;
  logic [VW-1:0]    val2;

  // Stage 3 registers
  stage_ctrl_t      ctrl3;
  logic [VW-1:0]    frac3;
  logic [VW-1:0]    sat3;
  logic [VW-1:0]    val3;

  // Stage 1 combinational
  logic [HUE_W-1:0] hue_wrap;
  sector_t          sector_next;
  logic [HUE_W-1:0] rem_wide;
  logic [XW-1:0]    sat_ext;
  logic [XW-1:0]    val_ext;
  logic [VW-1:0]    sat_next;
  logic [VW-1:0]    val_next;

  // Stage 2 and 3 combinational
  logic [XB-1:0]    scaled_next;
  logic [XB-1:0]    quot_est;
  logic [XB-1:0]    quot_rem;
  logic [XB-1:0]    quot_fix;

  // Wrap the hue, split it into sector and remainder, clamp s and v
  always_comb begin
    hue_wrap    = (pixel.hue >= HUE_FULL) ? '0 : pixel.hue;
    sector_next = hue_sector(hue_wrap);
    rem_wide    = hue_wrap - sector_base(sector_next);
    sat_ext     = XW'(pixel.saturation);
    val_ext     = XW'(pixel.brightness);
    sat_next    = (sat_ext > XW'(ONE)) ? ONE : VW'(sat_ext);
    val_next    = (val_ext > XW'(ONE)) ? ONE : VW'(val_ext);
  end

  // Scale the remainder: rem * ONE / 3840 = (rem << (FRAC_BITS - 8)) / 15
  assign scaled_next = XB'(rem1) << (FRAC_BITS - 8);

  // Correct the reciprocal estimate, which is low by at most one
  always_comb begin
    quot_est = prod2[2*XB-1:XB];
    quot_rem = scaled2 - ((quot_est << 4) - quot_est);
    quot_fix = (quot_rem >= FIFTEEN) ? quot_est + XB'(1) : quot_est;
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl1.valid <= 1'b0;
      ctrl2.valid <= 1'b0;
      ctrl3.valid <= 1'b0;
    end else begin
      ctrl1.valid <= in_valid;
      ctrl2.valid <= ctrl1.valid;
      ctrl3.valid <= ctrl2.valid;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    ctrl1.sector <= sector_next;
    rem1         <= rem_wide[REM_W-1:0];
    sat1         <= sat_next;
    val1         <= val_next;

    ctrl2.sector <= ctrl1.sector;
    scaled2      <= scaled_next;
    prod2        <= scaled_next * RECIP;
    sat2         <= sat1;
    val2         <= val1;

    ctrl3.sector <= ctrl2.sector;
    frac3        <= VW'(quot_fix);
    sat3         <= sat2;
    val3         <= val2;
  end

  assign out_ctrl = ctrl3;
  assign out_frac = frac3;
  assign out_sat  = sat3;
  assign out_val  = val3;

endmodule

`default_nettype wire

// ----- src/hsv2rgb_shade.sv -----
// ============================================================================
// hsv2rgb_shade
// Stages 4 and 5: form the shaded levels p = v(1-s), q = v(1-s*f) and
// t = v(1-s(1-f)), truncating every product; stage 4 has three multiplies.
// ============================================================================
`default_nettype none

module hsv2rgb_shade #(
  parameter int FRAC_BITS = 12
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire hsv2rgb_pkg::stage_ctrl_t in_ctrl,
  input  wire logic [FRAC_BITS:0]       in_frac,
  input  wire logic [FRAC_BITS:0]       in_sat,
  input  wire logic [FRAC_BITS:0]       in_val,
  output hsv2rgb_pkg::stage_ctrl_t      out_ctrl,
  output logic [FRAC_BITS:0]            out_val,
  output logic [FRAC_BITS:0]            out_p,
  output logic [FRAC_BITS:0]            out_q,
  output logic [FRAC_BITS:0]            out_t
);
  import hsv2rgb_pkg::*;

  localparam int VW = FRAC_BITS + 1;
  localparam logic [VW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // Stage 4 registers
  stage_ctrl_t     ctrl4;
  logic [2*VW-1:0] sf4;
  logic [2*VW-1:0] snf4;
  logic [2*VW-1:0] pprod4;
  logic [VW-1:0]   val4;

  // Stage 5 registers
  stage_ctrl_t     ctrl5;
  logic [2*VW-1:0] qprod5;
  logic [2*VW-1:0] tprod5;
  logic [VW-1:0]   p5;
  logic [VW-1:0]   val5;

  logic [VW-1:0]   q_scale;
  logic [VW-1:0]   t_scale;

  // Scale factors 1 - s*f and 1 - s(1-f)
  always_comb begin
    q_scale = ONE - VW'(sf4 >> FRAC_BITS);
    t_scale = ONE - VW'(snf4 >> FRAC_BITS);
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl4.valid <= 1'b0;
      ctrl5.valid <= 1'b0;
    end else begin
      ctrl4.valid <= in_ctrl.valid;
      ctrl5.valid <= ctrl4.valid;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    ctrl4.sector <= in_ctrl.sector;
    sf4          <= in_sat * in_frac;
    snf4         <= in_sat * (ONE - in_frac);
    pprod4       <= in_val * (ONE - in_sat);
    val4         <= in_val;

    ctrl5.sector <= ctrl4.sector;
    qprod5       <= val4 * q_scale;
    tprod5       <= val4 * t_scale;
    p5           <= VW'(pprod4 >> FRAC_BITS);
    val5         <= val4;
  end

  assign out_ctrl = ctrl5;
  assign out_val  = val5;
  assign out_p    = p5;
  assign out_q    = VW'(qprod5 >> FRAC_BITS);
  assign out_t    = VW'(tprod5 >> FRAC_BITS);

endmodule

`default_nettype wire

// ----- src/hsv2rgb_checker.sv -----
// ============================================================================
// hsv2rgb_checker
// Port-level checks of the HSV to RGB converter: fixed latency, one result
// per input beat, grey and black pixels.
// ============================================================================
`default_nettype none

module hsv2rgb_checker (
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    start,
  input wire logic                    busy,
  input wire hsv2rgb_pkg::hsv_pixel_t hsv,
  input wire logic                    done,
  input wire hsv2rgb_pkg::rgb_pixel_t rgb
);
  import hsv2rgb_pkg::*;

  // Every input beat yields a result after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##PIPE_LATENCY done)
    else $error("result missing after input beat");

  // No result without an input beat at the fixed latency before
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, PIPE_LATENCY))
    else $error("result without matching input beat");

  // Zero saturation gives a grey pixel
  a_grey: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && hsv.saturation == '0) |-> ##PIPE_LATENCY
      (rgb.red == rgb.green && rgb.green == rgb.blue))
    else $error("zero saturation did not give grey");

  // Zero brightness gives black
  a_black: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && hsv.brightness == '0) |-> ##PIPE_LATENCY
      (rgb.red == '0 && rgb.green == '0 && rgb.blue == '0))
    else $error("zero brightness did not give black");

endmodule

bind hsv_to_rgb_pixel_convert hsv2rgb_checker u_hsv2rgb_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .hsv   (hsv),
  .done  (done),
  .rgb   (rgb)
);

`default_nettype wire

// ----- verif/tb_hsv_to_rgb_pixel_convert.sv -----
// ============================================================================
// tb_hsv_to_rgb_pixel_convert
// Self-checking bench for the HSV to RGB pixel converter. A short table of
// corner pixels runs first, then about 1500 random pixels with random sender
// gaps. Typed rows carry their own color, the rest is predicted in fixed point,
// and each done beat is compared field by field with the oldest pending color.
// ============================================================================

module tb_hsv_to_rgb_pixel_convert;
  timeunit 1ns;
  timeprecision 1ps;

  import hsv2rgb_pkg::*;

  localparam int FRAC_BITS    = 12;
  localparam int UNIT         = 1 << FRAC_BITS;
  localparam int N_DIRECTED   = 24;
  localparam int N_RANDOM     = 1500;
  localparam int REPORT_MAX   = 10;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PX_W         = $bits(hsv_pixel_t);

  typedef struct packed {
    hsv_pixel_t px;
    logic       typed;
    rgb_pixel_t rgb;
  } corner_row_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       start;
  logic       busy;
  hsv_pixel_t hsv;
  logic       done;
  rgb_pixel_t rgb;

  rgb_pixel_t pending_rgb[$];
  int         error_count = 0;
  int         cycle_count = 0;
  int         burst_left  = 0;

  // Corner pixels; typed rows carry the color read straight off the formulas
  corner_row_t corner_rows [N_DIRECTED] = '{
    '{'{15'd0,     13'd0,    13'd0   }, 1'b1, '{13'd0,    13'd0,    13'd0   }},
    '{'{15'd0,     13'd0,    13'd4096}, 1'b1, '{13'd4096, 13'd4096, 13'd4096}},
    '{'{15'd12345, 13'd0,    13'd2000}, 1'b1, '{13'd2000, 13'd2000, 13'd2000}},
    '{'{15'd0,     13'd4096, 13'd4096}, 1'b1, '{13'd4096, 13'd0,    13'd0   }},
    '{'{15'd23040, 13'd4096, 13'd4096}, 1'b1, '{13'd4096, 13'd0,    13'd0   }},
    '{'{15'd32767, 13'd4096, 13'd4096}, 1'b1, '{13'd4096, 13'd0,    13'd0   }},
    '{'{15'd0,     13'd8191, 13'd8191}, 1'b1, '{13'd4096, 13'd0,    13'd0   }},
    '{'{15'd3840,  13'd4096, 13'd4096}, 1'b1, '{13'd4096, 13'd4096, 13'd0   }},
    '{'{15'd7680,  13'd4096, 13'd4096}, 1'b1, '{13'd0,    13'd4096, 13'd0   }},
    '{'{15'd11520, 13'd4096, 13'd4096}, 1'b1, '{13'd0,    13'd4096, 13'd4096}},
    '{'{15'd15360, 13'd4096, 13'd4096}, 1'b1, '{13'd0,    13'd0,    13'd4096}},
    '{'{15'd19200, 13'd4096, 13'd4096}, 1'b1, '{13'd4096, 13'd0,    13'd4096}},
    '{'{15'd0,     13'd4096, 13'd0   }, 1'b1, '{13'd0,    13'd0,    13'd0   }},
    '{'{15'd3839,  13'd4096, 13'd4096}, 1'b0, '0},
    '{'{15'd23039, 13'd4096, 13'd4096}, 1'b0, '0},
    '{'{15'd1920,  13'd2048, 13'd3000}, 1'b0, '0},
    '{'{15'd5760,  13'd1000, 13'd4095}, 1'b0, '0},
    '{'{15'd9600,  13'd4095, 13'd1   }, 1'b0, '0},
    '{'{15'd13440, 13'd1,    13'd4096}, 1'b0, '0},
    '{'{15'd17280, 13'd3000, 13'd2500}, 1'b0, '0},
    '{'{15'd21120, 13'd4096, 13'd8191}, 1'b0, '0},
    '{'{15'd23041, 13'd100,  13'd4096}, 1'b0, '0},
    '{'{15'd7679,  13'd8191, 13'd4096}, 1'b0, '0},
    '{'{15'd1,     13'd4096, 13'd4096}, 1'b0, '0}
  };

  hsv_to_rgb_pixel_convert #(
    .FRAC_BITS (FRAC_BITS)
  ) i_dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .hsv   (hsv),
    .done  (done),
    .rgb   (rgb)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Work out the color of one pixel: wrap hue, clamp s and v, shade, route
  function automatic rgb_pixel_t convert_pixel(input hsv_pixel_t px);
    logic [31:0] hue_w, sat, val, rem, frac, lvl_p, lvl_q, lvl_t;
    logic [31:0] chan_r, chan_g, chan_b;
    sector_t     sec;
    rgb_pixel_t  color;
    hue_w = 32'(px.hue);
    if (hue_w >= 32'(HUE_FULL)) hue_w = '0;
    sat = (32'(px.saturation) > UNIT) ? UNIT : 32'(px.saturation);
    val = (32'(px.brightness) > UNIT) ? UNIT : 32'(px.brightness);
    sec  = sector_t'(hue_w / 32'(HUE_SECTOR));
    rem  = hue_w % 32'(HUE_SECTOR);
    frac = (rem * UNIT) / 32'(HUE_SECTOR);
    lvl_p = (val * (UNIT - sat)) >> FRAC_BITS;
    lvl_q = (val * (UNIT - ((sat * frac) >> FRAC_BITS))) >> FRAC_BITS;
    lvl_t = (val * (UNIT - ((sat * (UNIT - frac)) >> FRAC_BITS))) >> FRAC_BITS;
    case (sec)
      SEC_RED: begin
        chan_r = val;   chan_g = lvl_t; chan_b = lvl_p;
      end
      SEC_YELLOW: begin
        chan_r = lvl_q; chan_g = val;   chan_b = lvl_p;
      end
      SEC_GREEN: begin
        chan_r = lvl_p; chan_g = val;   chan_b = lvl_t;
      end
      SEC_CYAN: begin
        chan_r = lvl_p; chan_g = lvl_q; chan_b = val;
      end
      SEC_BLUE: begin
        chan_r = lvl_t; chan_g = lvl_p; chan_b = val;
      end
      default: begin
        chan_r = val;   chan_g = lvl_p; chan_b = lvl_q;
      end
    endcase
    color.red   = chan_r[CHAN_W-1:0];
    color.green = chan_g[CHAN_W-1:0];
    color.blue  = chan_b[CHAN_W-1:0];
    return color;
  endfunction

  // Draw a pixel: mostly in range, with raw bits, sector edges and wraps mixed in
  function automatic hsv_pixel_t random_pixel();
    hsv_pixel_t px;
    int         base;
    int         pick [5] = '{0, 1, 4095, 4096, 8191};
    px.hue        = HUE_W'($urandom_range(0, 23039));
    px.saturation = CHAN_W'($urandom_range(0, UNIT));
    px.brightness = CHAN_W'($urandom_range(0, UNIT));
    case ($urandom_range(0, 9))
      0, 1: begin
        px.hue        = HUE_W'($urandom);
        px.saturation = CHAN_W'($urandom);
        px.brightness = CHAN_W'($urandom);
      end
      6: begin
        base = $urandom_range(0, 6) * int'(HUE_SECTOR) + $urandom_range(0, 4) - 2;
        px.hue = HUE_W'((base < 0) ? 0 : base);
      end
      7: begin
        px.saturation = CHAN_W'(pick[$urandom_range(0, 4)]);
        px.brightness = CHAN_W'(pick[$urandom_range(0, 4)]);
      end
      8: px.hue = HUE_W'($urandom_range(23040, 32767));
      9: begin
        px.saturation = CHAN_W'($urandom_range(0, 16));
        px.brightness = CHAN_W'($urandom_range(0, 16));
      end
      default: ;
    endcase
    return px;
  endfunction

  // Send one pixel beat after a random gap; called just after a rising edge
  task automatic send_pixel(input hsv_pixel_t px, input logic typed,
                            input rgb_pixel_t typed_rgb);
    int         gap;
    rgb_pixel_t predicted;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else begin
      gap = $urandom_range(0, 5);
      if ($urandom_range(0, 19) == 0) burst_left = $urandom_range(10, 60);
    end
    if (gap > 0) begin
      start <= 1'b0;
      hsv   <= hsv_pixel_t'(PX_W'({$urandom, $urandom}));
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    hsv   <= px;
    do @(posedge clk); while (busy);
    predicted   = typed ? typed_rgb : convert_pixel(px);
    pending_rgb = {pending_rgb, predicted};
  endtask

  // Hold the sender until every pending color has come back
  task automatic wait_drained();
    start <= 1'b0;
    while (pending_rgb.size() != 0) @(posedge clk);
  endtask

  // Check each done beat against the oldest pending color
  always @(posedge clk) begin
    rgb_pixel_t want;
    if (!rst && done) begin
      if (pending_rgb.size() == 0) begin
        if (error_count < REPORT_MAX)
          $display("%0t: done beat with nothing pending, rgb %0d %0d %0d",
                   $realtime, rgb.red, rgb.green, rgb.blue);
        error_count++;
      end else begin
        want = pending_rgb.pop_front();
        if (rgb.red !== want.red || rgb.green !== want.green ||
            rgb.blue !== want.blue) begin
          if (error_count < REPORT_MAX)
            $display("%0t: rgb mismatch, expected %0d %0d %0d, got %0d %0d %0d",
                     $realtime, want.red, want.green, want.blue,
                     rgb.red, rgb.green, rgb.blue);
          error_count++;
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_hsv_to_rgb_pixel_convert: errors");
      $finish;
    end
  end

  // Reset, corner table, random pixels, drain
  initial begin
    rst   = 1'b1;
    start = 1'b0;
    hsv   = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++)
      send_pixel(corner_rows[i].px, corner_rows[i].typed, corner_rows[i].rgb);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 2) wait_drained();
      send_pixel(random_pixel(), 1'b0, '0);
    end

    wait_drained();
    repeat (PIPE_LATENCY + 4) @(posedge clk);
    if (error_count == 0 && pending_rgb.size() == 0) begin
      $display("tb_hsv_to_rgb_pixel_convert: clean");
    end else begin
      $display("tb_hsv_to_rgb_pixel_convert: errors");
    end
    $finish;
  end

endmodule
